@@ sv/csed_pkg.sv @@
// Shared types, constants and character helpers for the C escape string decoder.
`default_nettype none
package csed_pkg;

   localparam int BYTE_W     = 8;
   localparam int SLOTS      = 4;
   localparam int SLOT_CNT_W = 3;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;

   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UP_F   = 8'h46;
   localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LO_F   = 8'h66;
   localparam logic [BYTE_W-1:0] CH_LO_V   = 8'h76;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } entry_type;

   // Bytes produced by one input byte, slot 0 first.
   typedef struct packed {
      logic [SLOT_CNT_W-1:0]   count;
      entry_type [SLOTS-1:0]   slot;
   } dec_out_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  val;
   } hex_type;

   typedef struct packed {
      logic              ok;
      logic [BYTE_W-1:0] val;
   } esc_type;

   function automatic hex_type hex_val(input logic [BYTE_W-1:0] c);
      hex_type           r;
      logic [BYTE_W-1:0] d;
      r = '0;
      d = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
         r.ok = 1'b1;
         r.val = d[3:0];
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         d = c - CH_UP_A + 8'd10;
         r.ok = 1'b1;
         r.val = d[3:0];
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         d = c - CH_LO_A + 8'd10;
         r.ok = 1'b1;
         r.val = d[3:0];
      end
      return r;
   endfunction

   function automatic esc_type simple_escape(input logic [BYTE_W-1:0] c);
      esc_type r;
      r.ok = 1'b1;
      case (c)
         8'h27:    r.val = 8'h27;
         8'h22:    r.val = 8'h22;
         8'h3F:    r.val = 8'h3F;
         CH_BSLASH: r.val = CH_BSLASH;
         CH_LO_A:  r.val = 8'd7;
         8'h62:    r.val = 8'd8;
         CH_LO_F:  r.val = 8'd12;
         8'h6E:    r.val = 8'd10;
         8'h72:    r.val = 8'd13;
         8'h74:    r.val = 8'd9;
         CH_LO_V:  r.val = 8'd11;
         default: begin
            r.ok = 1'b0;
            r.val = c;
         end
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/csed_decode.sv @@
// Escape-sequence state machine: turns one input byte into zero to four output bytes.
`default_nettype none
module csed_decode (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            advance,
   input  wire  [csed_pkg::BYTE_W-1:0]    in_byte,
   output csed_pkg::dec_out_type          dec_out
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ESC,
      PH_HEX0,
      PH_HEX1,
      PH_RAW1
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [csed_pkg::BYTE_W-1:0] held_ff, held_in;

   csed_pkg::hex_type hex_b, hex_h;
   csed_pkg::esc_type esc_b;
   logic [7:0]        hex_sum;

   always_comb begin
      hex_b   = csed_pkg::hex_val(in_byte);
      hex_h   = csed_pkg::hex_val(held_ff);
      esc_b   = csed_pkg::simple_escape(in_byte);
      hex_sum = {hex_h.val, hex_b.val};

      dec_out  = '0;
      phase_in = phase_ff;
      held_in  = held_ff;

      case (phase_ff)
         PH_ESC: begin
            if (in_byte == csed_pkg::CH_NUL) begin
               dec_out.count = 3'd2;
               dec_out.slot[0] = '{data: csed_pkg::CH_BSLASH, last: 1'b0};
               dec_out.slot[1] = '{data: csed_pkg::CH_NUL, last: 1'b1};
               phase_in = PH_IDLE;
               held_in  = '0;
            end else if (in_byte == csed_pkg::CH_X) begin
               phase_in = PH_HEX0;
            end else if (esc_b.ok) begin
               dec_out.count = 3'd1;
               dec_out.slot[0] = '{data: esc_b.val, last: 1'b0};
               phase_in = PH_IDLE;
            end else begin
               dec_out.count = 3'd2;
               dec_out.slot[0] = '{data: csed_pkg::CH_BSLASH, last: 1'b0};
               dec_out.slot[1] = '{data: in_byte, last: 1'b0};
               phase_in = PH_IDLE;
            end
         end
         PH_HEX0: begin
            dec_out.slot[0] = '{data: csed_pkg::CH_BSLASH, last: 1'b0};
            dec_out.slot[1] = '{data: csed_pkg::CH_X, last: 1'b0};
            if (in_byte == csed_pkg::CH_NUL) begin
               dec_out.count = 3'd3;
               dec_out.slot[2] = '{data: csed_pkg::CH_NUL, last: 1'b1};
               phase_in = PH_IDLE;
               held_in  = '0;
            end else if (hex_b.ok) begin
               dec_out.count = 3'd0;
               held_in  = in_byte;
               phase_in = PH_HEX1;
            end else begin
               dec_out.count = 3'd3;
               dec_out.slot[2] = '{data: in_byte, last: 1'b0};
               phase_in = PH_RAW1;
            end
         end
         PH_HEX1: begin
            dec_out.slot[0] = '{data: csed_pkg::CH_BSLASH, last: 1'b0};
            dec_out.slot[1] = '{data: csed_pkg::CH_X, last: 1'b0};
            dec_out.slot[2] = '{data: held_ff, last: 1'b0};
            phase_in = PH_IDLE;
            held_in  = '0;
            if (in_byte == csed_pkg::CH_NUL) begin
               dec_out.count = 3'd4;
               dec_out.slot[3] = '{data: csed_pkg::CH_NUL, last: 1'b1};
            end else if (hex_b.ok && hex_h.ok) begin
               // A zero value is kept visible as backslash and '0'.
               if (hex_sum == 8'd0) begin
                  dec_out.count = 3'd2;
                  dec_out.slot[1] = '{data: csed_pkg::CH_ZERO, last: 1'b0};
               end else begin
                  dec_out.count = 3'd1;
                  dec_out.slot[0] = '{data: hex_sum, last: 1'b0};
               end
            end else begin
               dec_out.count = 3'd4;
               dec_out.slot[3] = '{data: in_byte, last: 1'b0};
            end
         end
         PH_RAW1: begin
            dec_out.count = 3'd1;
            phase_in = PH_IDLE;
            if (in_byte == csed_pkg::CH_NUL) begin
               dec_out.slot[0] = '{data: csed_pkg::CH_NUL, last: 1'b1};
               held_in = '0;
            end else begin
               dec_out.slot[0] = '{data: in_byte, last: 1'b0};
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (in_byte == csed_pkg::CH_NUL) begin
               dec_out.count = 3'd1;
               dec_out.slot[0] = '{data: csed_pkg::CH_NUL, last: 1'b1};
               held_in = '0;
            end else if (in_byte == csed_pkg::CH_BSLASH) begin
               phase_in = PH_ESC;
            end else begin
               dec_out.count = 3'd1;
               dec_out.slot[0] = '{data: in_byte, last: 1'b0};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/csed_fifo.sv @@
// Result queue: takes up to four bytes per cycle, hands out one per cycle while out_ready is high.
`default_nettype none
module csed_fifo (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  csed_pkg::dec_out_type     push_data,
   output logic                      room,
   output logic                      out_valid,
   output csed_pkg::entry_type       out_entry,
   input  wire                       out_ready
);

   csed_pkg::entry_type              mem_ff [csed_pkg::FIFO_DEPTH];
   logic [csed_pkg::FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [csed_pkg::FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [csed_pkg::FIFO_CW-1:0]     count_ff, count_in;
   logic [csed_pkg::FIFO_CW-1:0]     push_n;
   logic                             pop;

   // Room for a full group of slots, counted without credit for this cycle's pop.
   assign room      = count_ff <= csed_pkg::FIFO_CW'(csed_pkg::FIFO_DEPTH - csed_pkg::SLOTS);
   assign out_valid = count_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      push_n    = push ? csed_pkg::FIFO_CW'(push_data.count) : '0;
      wr_ptr_in = wr_ptr_ff + csed_pkg::FIFO_AW'(push_n);
      rd_ptr_in = rd_ptr_ff + csed_pkg::FIFO_AW'(pop);
      count_in  = count_ff + push_n - csed_pkg::FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < csed_pkg::SLOTS; i++) begin
         if (csed_pkg::FIFO_CW'(i) < push_n) begin
            mem_ff[wr_ptr_ff + csed_pkg::FIFO_AW'(i)] <= push_data.slot[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/c_escape_string_decoder_unit.sv @@
// Top level of the C escape string decoder: input register, decoder and result queue.
// Path: an accepted byte is held in the input register, decoded combinationally and pushed
// into the queue, whose head entry is offered on rsp_tvalid. Throughput: one input byte per cycle while
// the queue has room; results drain one byte per cycle from an eight-entry queue while rsp_tready
// is high, and req_tready drops while a byte is held and fewer than four entries are free.
// Reset (synchronous, active high) empties the queue and returns the decoder to idle.
`default_nettype none
module c_escape_string_decoder_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // [7:0] in_byte
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [7:0]   rsp_tdata,   // [7:0] out_byte
   output logic         rsp_tlast    // out_last
);

   // Input register: holds one accepted byte until the decoder can push its results.
   logic                        in_valid_ff, in_valid_in;
   logic [csed_pkg::BYTE_W-1:0] in_byte_ff, in_byte_in;

   logic                        room;
   logic                        fire;
   logic                        req_xfer;
   csed_pkg::dec_out_type       dec_out;
   csed_pkg::entry_type         out_entry;

   // The decoder steps whenever a byte is held and the queue has room for a full group.
   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_byte_in  = req_xfer ? req_tdata : in_byte_ff;
      in_valid_in = req_xfer || (in_valid_ff && !fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   csed_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (fire),
      .in_byte (in_byte_ff),
      .dec_out (dec_out)
   );

   // Each result transfer on the output side pops one byte from the queue.
   csed_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (dec_out),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_entry (out_entry),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = out_entry.data;
   assign rsp_tlast = out_entry.last;

endmodule
`default_nettype wire
